[hdl/bsc_pkg.sv]
// Shared types and codes for the banker's safety check core.
// Item layouts, command, status and kind codes, default sizes.
// No dependencies.
`timescale 1ns / 1ps

package bsc_pkg;

   localparam int PROCS_DEF = 8;
   localparam int RES_DEF   = 4;

   localparam int AMT_W  = 8;
   localparam int WORK_W = 16;
   localparam int SEQ_W  = 3;

   localparam logic [2:0] CMD_WR_MAX   = 3'd0;
   localparam logic [2:0] CMD_WR_ALLOC = 3'd1;
   localparam logic [2:0] CMD_WR_AVAIL = 3'd2;
   localparam logic [2:0] CMD_STAGE    = 3'd3;
   localparam logic [2:0] CMD_APPLY    = 3'd4;
   localparam logic [2:0] CMD_CHECK    = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXCEEDS   = 2'd1;
   localparam logic [1:0] ST_NOT_AVAIL = 2'd2;
   localparam logic [1:0] ST_UNSAFE    = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_SEQ    = 1'b1;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [2:0]       proc_index;
      logic [1:0]       res_index;
      logic [AMT_W-1:0] amount;
   } req_item_type;

   typedef struct packed {
      logic             kind;
      logic [1:0]       status;
      logic [SEQ_W-1:0] seq_proc;
      logic             last;
   } rsp_item_type;

endpackage

[hdl/bankers_safety_check_core.sv]
// Banker's algorithm core: claim/allocation memories, request test and grant, safety scan.
// Write and stage items are taken in idle. Safety scan: up to PROCS passes over PROCS rows,
// a fit test per row (one memory read a cycle) plus an add pass per finished row. Check
// returns PROCS sequence items one per cycle if safe, else one unsafe status item; apply
// runs test, grant, scan and, if unsafe, rollback. One item at a time; busy high until the
// last result is out. Reset: clearing pass over both memories, busy high; receiver never stalls.
`timescale 1ns / 1ps

module bankers_safety_check_core #(
   parameter int PROCS = bsc_pkg::PROCS_DEF,
   parameter int RES   = bsc_pkg::RES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bsc_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output bsc_pkg::rsp_item_type rsp_item
);

   localparam int DEPTH = PROCS * RES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int CW    = $clog2(PROCS + 1);
   localparam int RW    = (RES > 1) ? $clog2(RES) : 1;
   localparam int RCW   = $clog2(RES + 1);
   localparam int AMT_W  = bsc_pkg::AMT_W;
   localparam int WORK_W = bsc_pkg::WORK_W;
   localparam int SEQ_W  = bsc_pkg::SEQ_W;

   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_REQ_TEST = 9'b000000100,
      S_GRANT    = 9'b000001000,
      S_UNDO     = 9'b000010000,
      S_INIT     = 9'b000100000,
      S_FIT      = 9'b001000000,
      S_ADD      = 9'b010000000,
      S_EMIT     = 9'b100000000
   } state_type;

   logic [AMT_W-1:0] max_claim_mem [DEPTH];
   logic [AMT_W-1:0] allocated_mem [DEPTH];

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [RCW-1:0]   r_ff, r_in;
   logic [PW-1:0]    p_ff, p_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             found_ff, found_in;
   logic             fail_ff, fail_in;
   logic             afail_ff, afail_in;
   logic             is_req_ff, is_req_in;
   logic [PW-1:0]    proc_ff, proc_in;
   logic [PW-1:0]    emit_ff, emit_in;
   logic [PROCS-1:0] done_ff, done_in;
   logic [WORK_W-1:0] work_ff [RES];
   logic [WORK_W-1:0] work_in [RES];
   logic [AMT_W-1:0] avail_ff [RES];
   logic [AMT_W-1:0] avail_in [RES];
   logic [AMT_W-1:0] staged_ff [RES];
   logic [AMT_W-1:0] staged_in [RES];
   logic [SEQ_W-1:0] seq_ff [PROCS];
   logic [SEQ_W-1:0] seq_in [PROCS];
   logic             rsp_strobe_ff, rsp_strobe_in;
   bsc_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic [AMT_W-1:0] max_rd_ff;
   logic [AMT_W-1:0] alloc_rd_ff;

   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_max_en;
   logic             wr_alloc_en;
   logic [AW-1:0]    wr_addr;
   logic [AMT_W-1:0] wr_data;

   logic [PW-1:0]    base_proc;
   logic [RCW-1:0]   c_cnt;
   logic [RW-1:0]    c_idx;
   logic             r_last;
   logic             r_issue;
   logic [AMT_W-1:0] need_val;
   logic             fit_bad;
   logic             req_need_bad;
   logic             req_avail_bad;
   logic             p_ok;
   logic             r_ok;
   logic             need_fail;
   logic             avail_fail;
   logic             adv;
   logic [CW-1:0]    adv_count;
   logic             adv_found;
   logic             fin_safe;
   logic             fin_unsafe;

   function automatic bsc_pkg::rsp_item_type status_item(input logic [1:0] st);
      bsc_pkg::rsp_item_type it;
      it.kind     = bsc_pkg::KIND_STATUS;
      it.status   = st;
      it.seq_proc = '0;
      it.last     = 1'b1;
      return it;
   endfunction

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   assign base_proc = (state_ff == S_FIT || state_ff == S_ADD) ? p_ff : proc_ff;
   assign c_cnt     = r_ff - 1'b1;
   assign c_idx     = c_cnt[RW-1:0];
   assign r_last    = (r_ff == RCW'(RES));
   assign r_issue   = (r_ff < RCW'(RES));
   assign rd_addr   = AW'(int'(base_proc) * RES + int'(r_ff));
   assign need_val  = max_rd_ff - alloc_rd_ff;
   assign fit_bad   = (max_rd_ff > alloc_rd_ff) && (WORK_W'(need_val) > work_ff[c_idx]);
   assign req_need_bad  = (alloc_rd_ff > max_rd_ff) || (staged_ff[c_idx] > need_val);
   assign req_avail_bad = (staged_ff[c_idx] > avail_ff[c_idx]);
   assign p_ok = (int'(req_item.proc_index) < PROCS);
   assign r_ok = (int'(req_item.res_index) < RES);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      r_in          = r_ff;
      p_in          = p_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      fail_in       = fail_ff;
      afail_in      = afail_ff;
      is_req_in     = is_req_ff;
      proc_in       = proc_ff;
      emit_in       = emit_ff;
      done_in       = done_ff;
      work_in       = work_ff;
      avail_in      = avail_ff;
      staged_in     = staged_ff;
      seq_in        = seq_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      rd_en         = 1'b0;
      wr_max_en     = 1'b0;
      wr_alloc_en   = 1'b0;
      wr_addr       = AW'(int'(base_proc) * RES + int'(c_cnt));
      wr_data       = '0;
      need_fail     = fail_ff;
      avail_fail    = afail_ff;
      adv           = 1'b0;
      adv_count     = count_ff;
      adv_found     = found_ff;
      fin_safe      = 1'b0;
      fin_unsafe    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_max_en   = 1'b1;
            wr_alloc_en = 1'b1;
            wr_addr     = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               wr_addr = AW'(int'(req_item.proc_index) * RES + int'(req_item.res_index));
               wr_data = req_item.amount;
               unique case (req_item.cmd)
                  bsc_pkg::CMD_WR_MAX: begin
                     wr_max_en = p_ok && r_ok;
                  end
                  bsc_pkg::CMD_WR_ALLOC: begin
                     wr_alloc_en = p_ok && r_ok;
                  end
                  bsc_pkg::CMD_WR_AVAIL: begin
                     if (r_ok) begin
                        avail_in[RW'(req_item.res_index)] = req_item.amount;
                     end
                  end
                  bsc_pkg::CMD_STAGE: begin
                     if (r_ok) begin
                        staged_in[RW'(req_item.res_index)] = req_item.amount;
                     end
                  end
                  bsc_pkg::CMD_APPLY: begin
                     if (p_ok) begin
                        proc_in  = PW'(req_item.proc_index);
                        r_in     = '0;
                        fail_in  = 1'b0;
                        afail_in = 1'b0;
                        state_in = S_REQ_TEST;
                     end
                  end
                  bsc_pkg::CMD_CHECK: begin
                     is_req_in = 1'b0;
                     state_in  = S_INIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_REQ_TEST: begin
            rd_en = r_issue;
            if (r_ff != '0) begin
               need_fail  = fail_ff || req_need_bad;
               avail_fail = afail_ff || req_avail_bad;
            end
            fail_in  = need_fail;
            afail_in = avail_fail;
            r_in     = r_ff + 1'b1;
            if (r_last) begin
               if (need_fail) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = status_item(bsc_pkg::ST_EXCEEDS);
                  state_in      = S_IDLE;
               end else if (avail_fail) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = status_item(bsc_pkg::ST_NOT_AVAIL);
                  state_in      = S_IDLE;
               end else begin
                  for (int j = 0; j < RES; j++) begin
                     avail_in[j] = avail_ff[j] - staged_ff[j];
                  end
                  r_in     = '0;
                  state_in = S_GRANT;
               end
            end
         end
         S_GRANT, S_UNDO: begin
            rd_en = r_issue;
            if (r_ff != '0) begin
               wr_alloc_en = 1'b1;
               wr_data     = (state_ff == S_GRANT) ? alloc_rd_ff + staged_ff[c_idx]
                                                   : alloc_rd_ff - staged_ff[c_idx];
            end
            r_in = r_ff + 1'b1;
            if (r_last) begin
               if (state_ff == S_GRANT) begin
                  is_req_in = 1'b1;
                  state_in  = S_INIT;
               end else begin
                  for (int j = 0; j < RES; j++) begin
                     avail_in[j] = avail_ff[j] + staged_ff[j];
                  end
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = status_item(bsc_pkg::ST_UNSAFE);
                  state_in      = S_IDLE;
               end
            end
         end
         S_INIT: begin
            for (int j = 0; j < RES; j++) begin
               work_in[j] = WORK_W'(avail_ff[j]);
            end
            done_in  = '0;
            count_in = '0;
            p_in     = '0;
            found_in = 1'b0;
            r_in     = '0;
            fail_in  = 1'b0;
            state_in = S_FIT;
         end
         S_FIT: begin
            if (done_ff[p_ff]) begin
               adv = 1'b1;
            end else begin
               rd_en = r_issue;
               if (r_ff != '0) begin
                  need_fail = fail_ff || fit_bad;
               end
               fail_in = need_fail;
               r_in    = r_ff + 1'b1;
               if (r_last) begin
                  if (need_fail) begin
                     adv = 1'b1;
                  end else begin
                     r_in     = '0;
                     state_in = S_ADD;
                  end
               end
            end
         end
         S_ADD: begin
            rd_en = r_issue;
            if (r_ff != '0) begin
               work_in[c_idx] = work_ff[c_idx] + WORK_W'(alloc_rd_ff);
            end
            r_in = r_ff + 1'b1;
            if (r_last) begin
               done_in[p_ff]              = 1'b1;
               seq_in[count_ff[PW-1:0]]   = SEQ_W'(p_ff);
               adv                        = 1'b1;
               adv_count                  = count_ff + 1'b1;
               adv_found                  = 1'b1;
            end
         end
         S_EMIT: begin
            rsp_strobe_in        = 1'b1;
            rsp_item_in.kind     = bsc_pkg::KIND_SEQ;
            rsp_item_in.status   = bsc_pkg::ST_OK;
            rsp_item_in.seq_proc = seq_ff[emit_ff];
            rsp_item_in.last     = (emit_ff == PW'(PROCS - 1));
            emit_in              = emit_ff + 1'b1;
            if (emit_ff == PW'(PROCS - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (adv) begin
         count_in = adv_count;
         found_in = adv_found;
         r_in     = '0;
         fail_in  = 1'b0;
         if (adv_count == CW'(PROCS)) begin
            fin_safe = 1'b1;
         end else if (p_ff == PW'(PROCS - 1)) begin
            if (!adv_found) begin
               fin_unsafe = 1'b1;
            end else begin
               p_in     = '0;
               found_in = 1'b0;
               state_in = S_FIT;
            end
         end else begin
            p_in     = p_ff + 1'b1;
            state_in = S_FIT;
         end
      end

      if (fin_safe) begin
         if (is_req_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_item_in   = status_item(bsc_pkg::ST_OK);
            state_in      = S_IDLE;
         end else begin
            emit_in  = '0;
            state_in = S_EMIT;
         end
      end

      if (fin_unsafe) begin
         if (is_req_ff) begin
            r_in     = '0;
            state_in = S_UNDO;
         end else begin
            rsp_strobe_in = 1'b1;
            rsp_item_in   = status_item(bsc_pkg::ST_UNSAFE);
            state_in      = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_max_en) begin
         max_claim_mem[wr_addr] <= wr_data;
      end
      if (wr_alloc_en) begin
         allocated_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         max_rd_ff   <= max_claim_mem[rd_addr];
         alloc_rd_ff <= allocated_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         r_ff          <= '0;
         p_ff          <= '0;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         fail_ff       <= 1'b0;
         afail_ff      <= 1'b0;
         is_req_ff     <= 1'b0;
         emit_ff       <= '0;
         done_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int j = 0; j < RES; j++) begin
            work_ff[j]   <= '0;
            avail_ff[j]  <= '0;
            staged_ff[j] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         r_ff          <= r_in;
         p_ff          <= p_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
         fail_ff       <= fail_in;
         afail_ff      <= afail_in;
         is_req_ff     <= is_req_in;
         emit_ff       <= emit_in;
         done_ff       <= done_in;
         rsp_strobe_ff <= rsp_strobe_in;
         work_ff       <= work_in;
         avail_ff      <= avail_in;
         staged_ff     <= staged_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff     <= proc_in;
      seq_ff      <= seq_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

[hdl/bsc_checker.sv]
// Port-level checker for the banker's safety check core, bound into bankers_safety_check_core.
// Depends on bsc_pkg and bankers_safety_check_core.
`timescale 1ns / 1ps

module bsc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input bsc_pkg::req_item_type req_item,
   input logic                  rsp_strobe,
   input bsc_pkg::rsp_item_type rsp_item
);

   logic accept_write;
   logic accept_check;

   assign accept_write = start && !busy &&
                         (req_item.cmd == bsc_pkg::CMD_WR_MAX ||
                          req_item.cmd == bsc_pkg::CMD_WR_ALLOC ||
                          req_item.cmd == bsc_pkg::CMD_WR_AVAIL ||
                          req_item.cmd == bsc_pkg::CMD_STAGE);
   assign accept_check = start && !busy && (req_item.cmd == bsc_pkg::CMD_CHECK);

   write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      accept_write |=> !busy)
      else $error("write item left the core busy");

   check_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept_check |=> busy)
      else $error("safety check item did not start work");

   sequence_runs_on: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |=> rsp_strobe && rsp_item.kind == bsc_pkg::KIND_SEQ)
      else $error("sequence items broke off before the last one");

   busy_mid_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("core idle while sequence items remain");

   gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |=> !rsp_strobe)
      else $error("result item followed the last one of an item");

endmodule

bind bankers_safety_check_core bsc_checker u_bsc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

[tb/tb.sv]
// Testbench for bankers_safety_check_core: directed and random command items, each result
// checked against an in-bench model of the claim/allocation tables and the safety scan.
// Depends on bsc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
   import bsc_pkg::*;

   localparam logic [2:0] CMD_SPARE_LO   = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI   = 3'd7;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         DRAIN_CYCLES   = 500;
   localparam int         SHOWN_ERRORS   = 10;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   bankers_safety_check_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   logic [AMT_W-1:0] claim_tbl [PROCS_DEF][RES_DEF];
   logic [AMT_W-1:0] alloc_tbl [PROCS_DEF][RES_DEF];
   logic [AMT_W-1:0] avail_vec [RES_DEF];
   logic [AMT_W-1:0] staged_vec [RES_DEF];
   logic [SEQ_W-1:0] safe_order [PROCS_DEF];

   rsp_item_type pending_outcomes[$];
   rsp_item_type want;
   int unsigned  mismatches;
   int unsigned  quiet_cycles;
   bit           idle_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int need_of(int p, int r);
      return int'(claim_tbl[p][r]) - int'(alloc_tbl[p][r]);
   endfunction

   // Repeated passes; any unfinished process whose need fits in work releases its allocation.
   function automatic bit bankers_scan();
      int work [RES_DEF];
      bit finished [PROCS_DEF];
      int cnt, scan_round, p, r;
      bit found, fit;
      for (r = 0; r < RES_DEF; r++) work[r] = avail_vec[r];
      for (p = 0; p < PROCS_DEF; p++) finished[p] = 1'b0;
      cnt = 0;
      for (scan_round = 0; scan_round < PROCS_DEF && cnt < PROCS_DEF; scan_round++) begin
         found = 1'b0;
         for (p = 0; p < PROCS_DEF; p++) begin
            if (!finished[p]) begin
               fit = 1'b1;
               for (r = 0; r < RES_DEF; r++)
                  if (need_of(p, r) > work[r]) fit = 1'b0;
               if (fit) begin
                  for (r = 0; r < RES_DEF; r++) work[r] += alloc_tbl[p][r];
                  finished[p] = 1'b1;
                  safe_order[cnt] = p[SEQ_W-1:0];
                  cnt++;
                  found = 1'b1;
               end
            end
         end
         if (!found) return 1'b0;
      end
      return cnt == PROCS_DEF;
   endfunction

   function automatic void push_outcome(logic kind, logic [1:0] status, int unsigned sp,
                                        logic last);
      rsp_item_type e;
      e.kind     = kind;
      e.status   = status;
      e.seq_proc = sp[SEQ_W-1:0];
      e.last     = last;
      pending_outcomes.push_back(e);
   endfunction

   function automatic void predict_item(req_item_type it);
      int p, r, j;
      bit over_need, over_avail;
      p = it.proc_index;
      r = it.res_index;
      case (it.cmd)
         CMD_WR_MAX:   claim_tbl[p][r] = it.amount;
         CMD_WR_ALLOC: alloc_tbl[p][r] = it.amount;
         CMD_WR_AVAIL: avail_vec[r] = it.amount;
         CMD_STAGE:    staged_vec[r] = it.amount;
         CMD_APPLY: begin
            over_need  = 1'b0;
            over_avail = 1'b0;
            for (j = 0; j < RES_DEF; j++) begin
               if (int'(staged_vec[j]) > need_of(p, j)) over_need = 1'b1;
               if (staged_vec[j] > avail_vec[j]) over_avail = 1'b1;
            end
            if (over_need) begin
               push_outcome(KIND_STATUS, ST_EXCEEDS, 0, 1'b1);
            end else if (over_avail) begin
               push_outcome(KIND_STATUS, ST_NOT_AVAIL, 0, 1'b1);
            end else begin
               for (j = 0; j < RES_DEF; j++) begin
                  avail_vec[j]    = avail_vec[j] - staged_vec[j];
                  alloc_tbl[p][j] = alloc_tbl[p][j] + staged_vec[j];
               end
               if (bankers_scan()) begin
                  push_outcome(KIND_STATUS, ST_OK, 0, 1'b1);
               end else begin
                  for (j = 0; j < RES_DEF; j++) begin
                     avail_vec[j]    = avail_vec[j] + staged_vec[j];
                     alloc_tbl[p][j] = alloc_tbl[p][j] - staged_vec[j];
                  end
                  push_outcome(KIND_STATUS, ST_UNSAFE, 0, 1'b1);
               end
            end
         end
         CMD_CHECK: begin
            if (bankers_scan()) begin
               for (j = 0; j < PROCS_DEF; j++)
                  push_outcome(KIND_SEQ, ST_OK, safe_order[j], j == PROCS_DEF - 1);
            end else begin
               push_outcome(KIND_STATUS, ST_UNSAFE, 0, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void log_mismatch(string what);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) $display("%0t: %s", $time, what);
   endfunction

   task automatic send_item(input logic [2:0] c, input int unsigned p, input int unsigned r,
                            input int unsigned amt);
      req_item_type it;
      int unsigned  gap;
      it.cmd        = c;
      it.proc_index = p[2:0];
      it.res_index  = r[1:0];
      it.amount     = amt[AMT_W-1:0];
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
      predict_item(it);
   endtask

   function automatic int unsigned pick_amount(int unsigned small_max);
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 255);
      return $urandom_range(0, small_max);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
               log_mismatch($sformatf("unexpected result kind=%0d status=%0d proc=%0d last=%0d",
                                      rsp_item.kind, rsp_item.status, rsp_item.seq_proc,
                                      rsp_item.last));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_item.kind !== want.kind || rsp_item.status !== want.status ||
                   rsp_item.seq_proc !== want.seq_proc || rsp_item.last !== want.last)
                  log_mismatch($sformatf(
                     "result exp kind=%0d status=%0d proc=%0d last=%0d, got %0d %0d %0d %0d",
                     want.kind, want.status, want.seq_proc, want.last, rsp_item.kind,
                     rsp_item.status, rsp_item.seq_proc, rsp_item.last));
            end
         end else if (rsp_strobe !== 1'b0) begin
            log_mismatch("result strobe unknown");
         end
         if (rsp_strobe === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no item moved for %0d cycles", quiet_cycles);
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   task automatic test_check_after_reset();
      send_item(CMD_CHECK, 0, 0, 0);
   endtask

   task automatic test_table_writes();
      send_item(CMD_WR_MAX, 7, 3, 255);
      send_item(CMD_WR_MAX, 0, 0, 0);
      send_item(CMD_CHECK, 0, 0, 0);
      send_item(CMD_WR_AVAIL, 0, 3, 255);
      send_item(CMD_CHECK, 7, 3, 255);
   endtask

   task automatic test_request_outcomes();
      send_item(CMD_STAGE, 0, 3, 255);
      send_item(CMD_APPLY, 0, 0, 0);
      send_item(CMD_APPLY, 7, 0, 0);
      send_item(CMD_CHECK, 0, 0, 0);
      send_item(CMD_APPLY, 7, 0, 0);
      send_item(CMD_WR_ALLOC, 3, 1, 200);
      send_item(CMD_WR_MAX, 2, 1, 100);
      send_item(CMD_STAGE, 0, 3, 0);
      send_item(CMD_STAGE, 0, 1, 50);
      send_item(CMD_WR_AVAIL, 0, 1, 10);
      send_item(CMD_APPLY, 2, 0, 0);
      send_item(CMD_CHECK, 0, 0, 0);
      send_item(CMD_WR_AVAIL, 0, 1, 60);
      send_item(CMD_WR_ALLOC, 3, 1, 0);
      send_item(CMD_APPLY, 2, 0, 0);
   endtask

   task automatic test_ignored_commands();
      send_item(CMD_SPARE_LO, $urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 255));
      send_item(CMD_SPARE_HI, 7, 3, 255);
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned sent, sel, p, r, amt;
      int          n;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 29) == 0) idle_on = ($urandom_range(0, 3) != 0);
         sel = $urandom_range(0, 99);
         p   = $urandom_range(0, PROCS_DEF - 1);
         r   = $urandom_range(0, RES_DEF - 1);
         if (sel < 10) begin
            send_item(CMD_WR_MAX, p, r, pick_amount(12));
            sent++;
         end else if (sel < 20) begin
            amt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, claim_tbl[p][r]);
            send_item(CMD_WR_ALLOC, p, r, amt);
            sent++;
         end else if (sel < 27) begin
            send_item(CMD_WR_AVAIL, p, r, pick_amount(20));
            sent++;
         end else if (sel < 52) begin
            // stage a request near the need of one process, then apply it
            for (r = 0; r < RES_DEF; r++) begin
               n = need_of(p, r);
               if ($urandom_range(0, 1) == 1 && int'(avail_vec[r]) < n) n = avail_vec[r];
               if (n < 0) n = 0;
               amt = $urandom_range(0, n);
               if ($urandom_range(0, 11) == 0) amt = (n < 255) ? n + 1 : 255;
               send_item(CMD_STAGE, p, r, amt);
            end
            send_item(CMD_APPLY, p, 0, 0);
            sent += RES_DEF + 1;
         end else if (sel < 72) begin
            send_item(CMD_CHECK, p, r, $urandom_range(0, 255));
            sent++;
         end else if (sel < 82) begin
            send_item(CMD_STAGE, p, r, pick_amount(6));
            sent++;
         end else if (sel < 92) begin
            send_item(CMD_APPLY, p, r, $urandom_range(0, 255));
            sent++;
         end else begin
            send_item($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO, p, r,
                      $urandom_range(0, 255));
            sent++;
         end
      end
   endtask

   initial begin
      int p, r;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      mismatches   = 0;
      quiet_cycles = 0;
      idle_on      = 1'b1;
      for (p = 0; p < PROCS_DEF; p++)
         for (r = 0; r < RES_DEF; r++) begin
            claim_tbl[p][r] = '0;
            alloc_tbl[p][r] = '0;
         end
      for (r = 0; r < RES_DEF; r++) begin
         avail_vec[r]  = '0;
         staged_vec[r] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_check_after_reset();
      test_table_writes();
      test_request_outcomes();
      test_ignored_commands();
      test_random_traffic(225);

      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
